// ----- rtl/core/battery_voltage_monitor_unit_assert.svh -----
`ifndef BATTERY_VOLTAGE_MONITOR_UNIT_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication, expects clk_i and rst_ni in scope
`define BVM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define BVM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/bvm_pkg.sv -----
package bvm_pkg;

  localparam int WindowSamplesDef = 10;
  localparam int AdcW      = 12;
  localparam int SumW      = 16;
  localparam int IdxW      = 4;
  localparam int MvW       = 13;
  localparam int FqW       = 17;
  localparam int PctW      = 7;
  localparam int OffW      = 11;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 11;
  localparam int InQDepth  = 4;
  localparam int OutQDepth = 2;

  localparam logic [PctW-1:0] LowThReset  = 7'd20;
  localparam logic [PctW-1:0] CritThReset = 7'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAL_OFFSET = 2'd0,
    CFG_LOW_TH     = 2'd1,
    CFG_CRIT_TH    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CHARGING = 3'd0,
    ST_CRITICAL = 3'd1,
    ST_LOW      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NORMAL   = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [OffW-1:0] cal_offset_mv;
    logic [PctW-1:0]        low_threshold;
    logic [PctW-1:0]        critical_threshold;
  } cfg_t;

  typedef struct packed {
    logic [MvW-1:0]  filtered_mv;
    logic [PctW-1:0] percent;
    logic            charging;
    logic [PctW-1:0] health;
    status_e         status_code;
    logic            low_alert;
    logic            critical_alert;
  } result_t;

  // li-ion state of charge from filtered voltage in q13.4
  function automatic logic [PctW-1:0] soc_lookup(logic [FqW-1:0] fq, logic chg_prev);
    logic [PctW-1:0] pct;
    if (chg_prev && fq > FqW'(4200 * 16))   pct = 7'd100;
    else if (fq >= FqW'(4150 * 16))         pct = 7'd100;
    else if (fq >= FqW'(4100 * 16))         pct = 7'd95;
    else if (fq >= FqW'(4050 * 16))         pct = 7'd90;
    else if (fq >= FqW'(4000 * 16))         pct = 7'd85;
    else if (fq >= FqW'(3950 * 16))         pct = 7'd75;
    else if (fq >= FqW'(3900 * 16))         pct = 7'd65;
    else if (fq >= FqW'(3850 * 16))         pct = 7'd55;
    else if (fq >= FqW'(3800 * 16))         pct = 7'd45;
    else if (fq >= FqW'(3750 * 16))         pct = 7'd35;
    else if (fq >= FqW'(3700 * 16))         pct = 7'd25;
    else if (fq >= FqW'(3650 * 16))         pct = 7'd15;
    else if (fq >= FqW'(3600 * 16))         pct = 7'd10;
    else if (fq >= FqW'(3550 * 16))         pct = 7'd5;
    else                                    pct = 7'd0;
    return pct;
  endfunction

endpackage

// ----- rtl/core/bvm_fifo.sv -----
module bvm_fifo #(
  parameter int Width = 16,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/bvm_front.sv -----
`include "battery_voltage_monitor_unit_assert.svh"

module bvm_front #(
  parameter int WindowSamples = bvm_pkg::WindowSamplesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [bvm_pkg::AdcW-1:0]    adc_sample_i,
  output logic                        full_o,
  output logic                        q_push_o,
  output logic [bvm_pkg::SumW-1:0]    q_data_o,
  input  logic                        q_full_i
);
  import bvm_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowSamples - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [SumW-1:0] sum_q, sum_d, sum_add;
  logic            accept, last;

  assign last     = (idx_q == LastIdx);
  assign full_o   = last && q_full_i;
  assign accept   = push_i && !full_o;
  assign sum_add  = sum_q + SumW'(adc_sample_i);
  assign q_push_o = accept && last;
  assign q_data_o = sum_add;

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    if (accept) begin
      if (last) begin
        idx_d = '0;
        sum_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
        sum_d = sum_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

  `BVM_ASSERT_IMP(a_idx_range, 1'b1, idx_q <= LastIdx)
  `BVM_ASSERT_NXT(a_idx_wrap, q_push_o, idx_q == '0 && sum_q == '0)
  `BVM_ASSERT_IMP(a_no_push_full, q_push_o, !q_full_i)

endmodule

// ----- rtl/core/bvm_back.sv -----
`include "battery_voltage_monitor_unit_assert.svh"

module bvm_back #(
  parameter int WindowSamples = bvm_pkg::WindowSamplesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bvm_pkg::cfg_t            cfg_i,
  input  logic                     in_empty_i,
  input  logic [bvm_pkg::SumW-1:0] in_data_i,
  output logic                     in_pop_o,
  input  logic                     out_full_i,
  output logic                     out_push_o,
  output bvm_pkg::result_t         out_data_o
);
  import bvm_pkg::*;

  // raw_mv = sum * 440 / (273 * window)
  localparam int NumW    = 25;
  localparam int Div     = 273 * WindowSamples;
  localparam int DivBits = $clog2(Div);
  localparam int Shift   = NumW + DivBits;
  localparam int RecipW  = NumW + 2;
  localparam longint unsigned RecipL = ((64'd1 << Shift) + 64'(Div) - 64'd1) / 64'(Div);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam int ProdW   = NumW + RecipW;

  localparam int FiltXW  = 21;
  localparam int Rec10W  = 21;
  localparam logic [Rec10W-1:0] Rec10 = Rec10W'(1677722);
  localparam int Prod10W = FiltXW + Rec10W;

  localparam int DiffW   = 26;
  localparam logic [DiffW-1:0] Rec12 = DiffW'(5462);

  logic                 a_valid_q, b_valid_q, c_valid_q;
  logic [NumW-1:0]      num_q;
  logic [MvW-1:0]       raw_b_q, raw_c_q;
  logic [FqW-1:0]       fq_q, fq_d;
  logic                 chg_q, chg_d;
  logic [MvW-1:0]       peak_q, peak_d;
  logic                 low_sent_q, low_sent_d, crit_sent_q, crit_sent_d;
  logic                 adv;
  logic [ProdW-1:0]     raw_prod;
  logic signed [MvW:0]  cal_s;
  logic [MvW-1:0]       cal;
  logic [FiltXW-1:0]    filt_x;
  logic [Prod10W-1:0]   filt_prod;
  logic [PctW-1:0]      pct, health;
  logic [MvW-1:0]       peak_diff;
  logic [DiffW-1:0]     health_prod;
  logic [8:0]           health_raw;
  logic                 low_pulse, crit_pulse;
  status_e              status;

  assign adv        = !(c_valid_q && out_full_i);
  assign in_pop_o   = adv && !in_empty_i;
  assign out_push_o = c_valid_q && !out_full_i;

  assign raw_prod  = ProdW'(num_q) * ProdW'(Recip);

  // calibration and 0.7/0.3 filter, divide by ten through reciprocal
  assign cal_s     = $signed({1'b0, raw_b_q}) + (MvW + 1)'(cfg_i.cal_offset_mv);
  assign cal       = (cal_s < 0) ? '0 : cal_s[MvW-1:0];
  assign filt_x    = FiltXW'(fq_q) * FiltXW'(7) + FiltXW'(cal) * FiltXW'(48);
  assign filt_prod = Prod10W'(filt_x) * Prod10W'(Rec10);
  assign fq_d      = filt_prod[24 +: FqW];

  assign pct       = soc_lookup(fq_q, chg_q);
  assign chg_d     = (raw_c_q > MvW'(4300));
  assign peak_d    = (raw_c_q > peak_q) ? raw_c_q : peak_q;

  assign peak_diff   = peak_d - MvW'(3000);
  assign health_prod = DiffW'(peak_diff) * Rec12;
  assign health_raw  = health_prod[16 +: 9];

  always_comb begin
    if (peak_d <= MvW'(3000)) begin
      health = '0;
    end else if (health_raw > 9'd100) begin
      health = 7'd100;
    end else begin
      health = health_raw[PctW-1:0];
    end
  end

  always_comb begin
    low_pulse   = 1'b0;
    crit_pulse  = 1'b0;
    low_sent_d  = low_sent_q;
    crit_sent_d = crit_sent_q;
    if (pct <= cfg_i.critical_threshold && !crit_sent_q) begin
      crit_pulse  = 1'b1;
      crit_sent_d = 1'b1;
      low_sent_d  = 1'b1;
    end else if (pct <= cfg_i.low_threshold && !low_sent_q) begin
      low_pulse  = 1'b1;
      low_sent_d = 1'b1;
    end else if (pct > cfg_i.low_threshold) begin
      low_sent_d = 1'b0;
      if (pct > cfg_i.critical_threshold) begin
        crit_sent_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (chg_d) begin
      status = ST_CHARGING;
    end else if (pct <= cfg_i.critical_threshold) begin
      status = ST_CRITICAL;
    end else if (pct <= cfg_i.low_threshold) begin
      status = ST_LOW;
    end else if (pct >= 7'd90) begin
      status = ST_FULL;
    end else begin
      status = ST_NORMAL;
    end
  end

  always_comb begin
    out_data_o.filtered_mv    = fq_q[FqW-1:4];
    out_data_o.percent        = pct;
    out_data_o.charging       = chg_d;
    out_data_o.health         = health;
    out_data_o.status_code    = status;
    out_data_o.low_alert      = low_pulse;
    out_data_o.critical_alert = crit_pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      fq_q        <= '0;
      chg_q       <= 1'b0;
      peak_q      <= '0;
      low_sent_q  <= 1'b0;
      crit_sent_q <= 1'b0;
    end else begin
      if (adv) begin
        a_valid_q <= in_pop_o;
        b_valid_q <= a_valid_q;
        c_valid_q <= b_valid_q;
        if (b_valid_q) begin
          fq_q <= fq_d;
        end
      end
      if (out_push_o) begin
        chg_q       <= chg_d;
        peak_q      <= peak_d;
        low_sent_q  <= low_sent_d;
        crit_sent_q <= crit_sent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q   <= NumW'(in_data_i) * NumW'(440);
      raw_b_q <= raw_prod[Shift +: MvW];
      raw_c_q <= raw_b_q;
    end
  end

  `BVM_ASSERT_IMP(a_alert_excl, out_push_o, !(low_pulse && crit_pulse))
  `BVM_ASSERT_NXT(a_crit_latch, out_push_o && crit_pulse, crit_sent_q && low_sent_q)
  `BVM_ASSERT_IMP(a_health_cap, out_push_o, health <= 7'd100)
  `BVM_ASSERT_NXT(a_stall_hold, c_valid_q && out_full_i, c_valid_q && $stable(fq_q))

endmodule

// ----- rtl/core/battery_voltage_monitor_unit.sv -----
// Battery voltage monitor. ADC samples are taken one per clock while full_o is low and summed
// in windows of WindowSamples; each completed window yields one result item on the output
// queue (calibrated voltage through a 0.7/0.3 filter, li-ion percentage, charging flag, health,
// status and one-shot low/critical alerts). The front end accepts a sample every cycle and only
// stalls on the last sample of a window when its four-entry window queue is full. The back end
// is a three-stage pipeline (scale multiply, reciprocal divide, calibrate and filter) followed by
// the table lookup and alert logic; the filter state and alert latches feed back, so one
// window per cycle is taken while the result queue is not full. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i, by the user only while idle (not enforced).
module battery_voltage_monitor_unit #(
  parameter int WindowSamples = bvm_pkg::WindowSamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [bvm_pkg::AdcW-1:0]      adc_sample_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [bvm_pkg::MvW-1:0]       filtered_mv_o,
  output logic [bvm_pkg::PctW-1:0]      percent_o,
  output logic                          charging_o,
  output logic [bvm_pkg::PctW-1:0]      health_o,
  output logic [2:0]                    status_code_o,
  output logic                          low_alert_o,
  output logic                          critical_alert_o,
  input  logic                          cfg_we_i,
  input  logic [bvm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bvm_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import bvm_pkg::*;

  localparam int ResW = $bits(result_t);

  cfg_t            cfg_q;
  logic            win_push, win_full, win_empty, win_pop;
  logic [SumW-1:0] win_wdata, win_rdata;
  logic            res_push, res_full;
  result_t         res_wdata, res_rdata;
  logic [ResW-1:0] res_rdata_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_offset_mv      <= '0;
      cfg_q.low_threshold      <= LowThReset;
      cfg_q.critical_threshold <= CritThReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAL_OFFSET: cfg_q.cal_offset_mv      <= $signed(cfg_wdata_i[OffW-1:0]);
        CFG_LOW_TH:     cfg_q.low_threshold      <= cfg_wdata_i[PctW-1:0];
        CFG_CRIT_TH:    cfg_q.critical_threshold <= cfg_wdata_i[PctW-1:0];
        default: ;
      endcase
    end
  end

  bvm_front #(
    .WindowSamples(WindowSamples)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .adc_sample_i(adc_sample_i),
    .full_o      (full_o),
    .q_push_o    (win_push),
    .q_data_o    (win_wdata),
    .q_full_i    (win_full)
  );

  bvm_fifo #(
    .Width(SumW),
    .Depth(InQDepth)
  ) u_win_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (win_push),
    .wdata_i(win_wdata),
    .full_o (win_full),
    .pop_i  (win_pop),
    .rdata_o(win_rdata),
    .empty_o(win_empty)
  );

  bvm_back #(
    .WindowSamples(WindowSamples)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_empty_i(win_empty),
    .in_data_i (win_rdata),
    .in_pop_o  (win_pop),
    .out_full_i(res_full),
    .out_push_o(res_push),
    .out_data_o(res_wdata)
  );

  bvm_fifo #(
    .Width(ResW),
    .Depth(OutQDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_wdata),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata_raw),
    .empty_o(empty_o)
  );

  assign res_rdata        = result_t'(res_rdata_raw);
  assign filtered_mv_o    = res_rdata.filtered_mv;
  assign percent_o        = res_rdata.percent;
  assign charging_o       = res_rdata.charging;
  assign health_o         = res_rdata.health;
  assign status_code_o    = res_rdata.status_code;
  assign low_alert_o      = res_rdata.low_alert;
  assign critical_alert_o = res_rdata.critical_alert;

endmodule
